[src/bzc_pkg.sv]
// Shared types, constants and lookup tables of the Bazeries cipher stream.
`default_nettype none

package bzc_pkg;

    localparam int SQUARE_SIDE    = 5;
    localparam int CELL_COUNT     = SQUARE_SIDE * SQUARE_SIDE;
    localparam int GROUP_MAX      = 9;
    localparam int GROUP_W        = $clog2(GROUP_MAX + 1);
    localparam int SEQ_DIGITS_MAX = 6;
    localparam int DIGIT_MAX      = 9;
    localparam int LETTER_I       = 8;
    localparam int LETTER_LAST    = 25;
    localparam int CELL_LETTERS   = 26;
    localparam int DESC_DEPTH     = 4;
    localparam int CFG_DATA_W     = 50;
    localparam int KEY_BITS       = 5 * CELL_COUNT;

    typedef enum logic [2:0] {
        CFG_ENCODE_MODE,
        CFG_KEY_LOW,
        CFG_KEY_MID,
        CFG_KEY_HIGH,
        CFG_SEQ_DIGITS,
        CFG_SEQ_COUNT
    } cfg_index_t;

    typedef logic [4:0]         letter_t;
    typedef logic [GROUP_W-1:0] count_t;
    typedef logic [31:0][4:0]   lut_t;

    typedef struct packed {
        logic                encode_mode;
        logic [KEY_BITS-1:0] cells;
        logic [23:0]         digits;
        logic [2:0]          count;
    } bzc_cfg_t;

    // Front to queue: one substituted letter, and the close of a group.
    typedef struct packed {
        logic    wr_en;
        logic    blank;
        letter_t letter;
        logic    grp_done;
        count_t  count;
        logic    msg_end;
    } bzc_push_t;

    typedef struct packed {
        logic ring_full;
        logic desc_full;
    } bzc_qstat_t;

    typedef struct packed {
        count_t count;
        logic   msg_end;
    } bzc_desc_t;

    typedef struct packed {
        logic      valid;
        bzc_desc_t desc;
    } bzc_head_t;

    // Back to queue: group pop, ring read, and release of a group's slots.
    typedef struct packed {
        logic   pop;
        logic   rd_en;
        logic   grp_free;
        count_t free_count;
    } bzc_rd_t;

    // Letter a..z (j folded onto i) to the transposed square cell.
    function automatic lut_t build_enc_lut();
        lut_t lut;
        int   p;
        lut = '0;
        for (int k = 0; k <= LETTER_LAST; k++)
        begin
            p = (k <= LETTER_I) ? k : k - 1;
            lut[k] = 5'((p % SQUARE_SIDE) * SQUARE_SIDE + p / SQUARE_SIDE);
        end
        return lut;
    endfunction

    // Square cell to the transposed alphabet letter, skipping j.
    function automatic lut_t build_dec_lut();
        lut_t lut;
        int   t;
        lut = '0;
        for (int q = 0; q < CELL_COUNT; q++)
        begin
            t = (q % SQUARE_SIDE) * SQUARE_SIDE + q / SQUARE_SIDE;
            if (t > LETTER_I)
            begin
                t = t + 1;
            end
            lut[q] = 5'(t);
        end
        return lut;
    endfunction

    localparam lut_t ENC_LUT = build_enc_lut();
    localparam lut_t DEC_LUT = build_dec_lut();

endpackage

`default_nettype wire

[src/bzc_front.sv]
// Front part: accepts letters, substitutes them and closes groups.
`default_nettype none

module bzc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bzc_pkg::bzc_cfg_t   cfg,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire bzc_pkg::letter_t    letter_in,
    input  wire logic                message_end,
    input  wire bzc_pkg::bzc_qstat_t qstat,
    output bzc_pkg::bzc_push_t       push
);

    bzc_pkg::count_t  fill_reg;
    bzc_pkg::count_t  fill_next;
    logic [2:0]       pos_reg;
    logic [2:0]       pos_next;

    logic             accept;
    logic [4:0]       cell_val [32];
    logic [3:0]       dig [8];
    logic [31:0]      dig_word;
    logic [2:0]       n_digits;
    logic [2:0]       start_pos;
    logic [3:0]       cand;
    logic             dig_found;
    logic [2:0]       found_pos;
    bzc_pkg::count_t  grp_len;
    bzc_pkg::count_t  fill_inc;
    logic             emit;
    logic [2:0]       pos_inc;

    bzc_pkg::letter_t enc_cell;
    bzc_pkg::letter_t enc_val;
    bzc_pkg::letter_t letter_p1;
    logic             dec_found;
    bzc_pkg::letter_t dec_cell;
    logic             sub_blank;
    bzc_pkg::letter_t sub_letter;

    assign in_stall = qstat.ring_full | qstat.desc_full;
    assign accept   = in_valid & ~in_stall;

    // Substitution through the keyed square.
    always_comb
    begin
        for (int k = 0; k < 32; k++)
        begin
            if (k < bzc_pkg::CELL_COUNT)
            begin
                cell_val[k] = cfg.cells[5*k +: 5];
            end
            else
            begin
                cell_val[k] = '0;
            end
        end

        enc_cell  = bzc_pkg::ENC_LUT[letter_in];
        enc_val   = cell_val[enc_cell];
        letter_p1 = letter_in + 5'd1;

        // Highest matching cell wins.
        dec_found = 1'b0;
        dec_cell  = '0;
        for (int q = 0; q < bzc_pkg::CELL_COUNT; q++)
        begin
            if (cell_val[q] == letter_p1)
            begin
                dec_found = 1'b1;
                dec_cell  = 5'(q);
            end
        end

        if (letter_in > 5'(bzc_pkg::LETTER_LAST))
        begin
            sub_blank  = 1'b1;
            sub_letter = '0;
        end
        else if (cfg.encode_mode)
        begin
            sub_blank  = (enc_val == 5'd0) || (enc_val > 5'(bzc_pkg::CELL_LETTERS));
            sub_letter = sub_blank ? 5'd0 : enc_val - 5'd1;
        end
        else
        begin
            sub_blank  = ~dec_found;
            sub_letter = dec_found ? bzc_pkg::DEC_LUT[dec_cell] : 5'd0;
        end
    end

    // Group length: next nonzero digit from the current position.
    always_comb
    begin
        dig_word = {8'd0, cfg.digits};
        for (int k = 0; k < 8; k++)
        begin
            dig[k] = (dig_word[4*k +: 4] > 4'(bzc_pkg::DIGIT_MAX))
                   ? 4'(bzc_pkg::DIGIT_MAX) : dig_word[4*k +: 4];
        end

        if (cfg.count == 3'd0)
        begin
            n_digits = 3'd1;
        end
        else if (cfg.count > 3'(bzc_pkg::SEQ_DIGITS_MAX))
        begin
            n_digits = 3'(bzc_pkg::SEQ_DIGITS_MAX);
        end
        else
        begin
            n_digits = cfg.count;
        end

        start_pos = (pos_reg >= n_digits) ? 3'd0 : pos_reg;
        dig_found = 1'b0;
        found_pos = '0;
        grp_len   = bzc_pkg::count_t'(1);
        cand      = '0;
        for (int i = 0; i < bzc_pkg::SEQ_DIGITS_MAX; i++)
        begin
            cand = {1'b0, start_pos} + 4'(i);
            if (cand >= {1'b0, n_digits})
            begin
                cand = cand - {1'b0, n_digits};
            end
            if ((i < int'(n_digits)) && !dig_found && (dig[cand[2:0]] != 4'd0))
            begin
                dig_found = 1'b1;
                found_pos = cand[2:0];
                grp_len   = bzc_pkg::count_t'(dig[cand[2:0]]);
            end
        end

        fill_inc = fill_reg + bzc_pkg::count_t'(1);
        emit     = (fill_inc >= grp_len) || message_end;
        pos_inc  = (found_pos + 3'd1 == n_digits) ? 3'd0 : found_pos + 3'd1;

        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            if (!emit)
            begin
                fill_next = fill_inc;
                pos_next  = found_pos;
            end
            else
            begin
                fill_next = '0;
                pos_next  = message_end ? 3'd0 : pos_inc;
            end
        end
    end

    always_comb
    begin
        push.wr_en    = accept;
        push.blank    = sub_blank;
        push.letter   = sub_letter;
        push.grp_done = accept & emit;
        push.count    = fill_inc;
        push.msg_end  = message_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

[src/bzc_queue.sv]
// Queue between front and back: letter ring memory and group descriptor FIFO.
`default_nettype none

module bzc_queue #(
    parameter int RING_DEPTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bzc_pkg::bzc_push_t        push,
    output bzc_pkg::bzc_qstat_t            qstat,
    input  wire bzc_pkg::bzc_rd_t          rd,
    input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    output bzc_pkg::bzc_head_t             head,
    output logic [5:0]                     rd_data
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int OCC_W = $clog2(RING_DEPTH + 1);
    localparam int DW    = $clog2(bzc_pkg::DESC_DEPTH);
    localparam int DCW   = $clog2(bzc_pkg::DESC_DEPTH + 1);

    logic [5:0]          ring_mem [RING_DEPTH];
    logic [5:0]          rd_data_reg;
    logic [AW-1:0]       wr_ptr_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    bzc_pkg::bzc_desc_t  desc_mem [bzc_pkg::DESC_DEPTH];
    logic [DW-1:0]       dwr_ptr_reg;
    logic [DW-1:0]       drd_ptr_reg;
    logic [DCW-1:0]      dcnt_reg;
    logic [DCW-1:0]      dcnt_next;

    always_comb
    begin
        // Groups are read in reverse, so hold a group's slots until its last read.
        occ_next = occ_reg;
        if (push.wr_en)
        begin
            occ_next = occ_next + OCC_W'(1);
        end
        if (rd.grp_free)
        begin
            occ_next = occ_next - OCC_W'(rd.free_count);
        end

        dcnt_next = dcnt_reg;
        if (push.grp_done && !rd.pop)
        begin
            dcnt_next = dcnt_reg + DCW'(1);
        end
        else if (!push.grp_done && rd.pop)
        begin
            dcnt_next = dcnt_reg - DCW'(1);
        end

        qstat.ring_full = (occ_reg == OCC_W'(RING_DEPTH));
        qstat.desc_full = (dcnt_reg == DCW'(bzc_pkg::DESC_DEPTH));
        head.valid      = (dcnt_reg != '0);
        head.desc       = desc_mem[drd_ptr_reg];
    end

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (push.wr_en)
        begin
            ring_mem[wr_ptr_reg] <= {push.blank, push.letter};
        end
        if (rd.rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (push.grp_done)
        begin
            desc_mem[dwr_ptr_reg] <= '{count: push.count, msg_end: push.msg_end};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            occ_reg     <= '0;
            dwr_ptr_reg <= '0;
            drd_ptr_reg <= '0;
            dcnt_reg    <= '0;
        end
        else
        begin
            occ_reg  <= occ_next;
            dcnt_reg <= dcnt_next;
            if (push.wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (push.grp_done)
            begin
                dwr_ptr_reg <= dwr_ptr_reg + DW'(1);
            end
            if (rd.pop)
            begin
                drd_ptr_reg <= drd_ptr_reg + DW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/bzc_back.sv]
// Back part: walks each closed group in reverse and drives the output register.
`default_nettype none

module bzc_back #(
    parameter int RING_DEPTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bzc_pkg::bzc_head_t        head,
    output bzc_pkg::bzc_rd_t               rd,
    output logic [$clog2(RING_DEPTH)-1:0]  rd_addr,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           group_last,
    output logic                           message_last
);

    localparam int AW = $clog2(RING_DEPTH);

    logic            active_reg;
    bzc_pkg::count_t remain_reg;
    bzc_pkg::count_t len_reg;
    logic            end_reg;
    logic [AW-1:0]   base_reg;
    logic            out_valid_reg;
    logic            group_last_reg;
    logic            message_last_reg;

    bzc_pkg::count_t cur_remain;
    bzc_pkg::count_t cur_len;
    logic            cur_end;
    logic            can_out;
    logic            issue;
    logic            last;

    always_comb
    begin
        cur_remain    = active_reg ? remain_reg : head.desc.count;
        cur_len       = active_reg ? len_reg    : head.desc.count;
        cur_end       = active_reg ? end_reg    : head.desc.msg_end;
        can_out       = ~out_valid_reg | ~out_stall;
        issue         = (active_reg | head.valid) & can_out;
        last          = (cur_remain == bzc_pkg::count_t'(1));
        rd_addr       = base_reg + AW'(cur_remain) - AW'(1);
        rd.rd_en      = issue;
        rd.pop        = issue & ~active_reg;
        rd.grp_free   = issue & last;
        rd.free_count = cur_len;
    end

    assign out_valid    = out_valid_reg;
    assign group_last   = group_last_reg;
    assign message_last = message_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            remain_reg       <= '0;
            len_reg          <= '0;
            end_reg          <= 1'b0;
            base_reg         <= '0;
            out_valid_reg    <= 1'b0;
            group_last_reg   <= 1'b0;
            message_last_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                if (last)
                begin
                    active_reg <= 1'b0;
                    base_reg   <= base_reg + AW'(cur_len);
                end
                else
                begin
                    active_reg <= 1'b1;
                    remain_reg <= cur_remain - bzc_pkg::count_t'(1);
                    len_reg    <= cur_len;
                    end_reg    <= cur_end;
                end
            end
            if (can_out)
            begin
                out_valid_reg    <= issue;
                group_last_reg   <= last;
                message_last_reg <= last & cur_end;
            end
        end
    end

endmodule

`default_nettype wire

[src/bazeries_cipher_stream.sv]
// Top level of the Bazeries cipher stream: configuration registers and block wiring.
//
// Each input item is one letter (0 = a .. 25 = z) with an end-of-message mark.
// The letter is substituted through a 5x5 keyed square held in configuration:
// encode reads the cell at the transposed alphabet position (j taken as i),
// decode finds the highest cell holding the letter and returns the transposed
// alphabet letter, skipping j; a missing letter or an empty cell gives a blank
// item with letter_out at zero. Substituted letters are collected into groups
// whose lengths follow the nonzero key digits in turn (groups of one when all
// digits are zero), and each group is sent out reversed, with group_last on
// its final item. A message end closes the current group at once, flags
// message_last on its final item and restarts the digit cycle at digit 0.
// The block takes one input item per cycle while in_stall is low and sends
// one result item per cycle while out_stall is low. The front substitutes and
// writes each letter into a ring of RING_DEPTH entries in the cycle it is
// accepted; a closed group is queued as a descriptor (up to four groups
// waiting), and the back reads the ring into the output register once per cycle
// unless the output stalls, so with the back idle a group's first result is
// read once its descriptor is queued. A group's ring slots come free once its
// last letter has been read out. in_stall rises only when the ring or the
// descriptor queue is full, which happens when the output side stalls for long.
// No clearing pass runs after reset. Write configuration only while no result
// is pending; registers are written by index through cfg_write.
`default_nettype none

module bazeries_cipher_stream #(
    parameter int RING_DEPTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [bzc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [4:0]                        letter_in,
    input  wire logic                              message_end,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [4:0]                             letter_out,
    output logic                                   blank_out,
    output logic                                   group_last,
    output logic                                   message_last
);

    localparam int AW = $clog2(RING_DEPTH);

    // Configuration registers, reset to the documented defaults.
    logic        encode_mode_reg;
    logic [49:0] key_low_reg;
    logic [49:0] key_mid_reg;
    logic [24:0] key_high_reg;
    logic [23:0] seq_digits_reg;
    logic [2:0]  seq_count_reg;

    bzc_pkg::bzc_cfg_t   cfg;
    bzc_pkg::bzc_push_t  push;
    bzc_pkg::bzc_qstat_t qstat;
    bzc_pkg::bzc_head_t  head;
    bzc_pkg::bzc_rd_t    rd;
    logic [AW-1:0]       rd_addr;
    logic [5:0]          rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encode_mode_reg <= 1'b0;
            key_low_reg     <= '0;
            key_mid_reg     <= '0;
            key_high_reg    <= '0;
            seq_digits_reg  <= 24'd1;
            seq_count_reg   <= 3'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bzc_pkg::CFG_ENCODE_MODE: encode_mode_reg <= cfg_data[0];
                bzc_pkg::CFG_KEY_LOW:     key_low_reg     <= cfg_data[49:0];
                bzc_pkg::CFG_KEY_MID:     key_mid_reg     <= cfg_data[49:0];
                bzc_pkg::CFG_KEY_HIGH:    key_high_reg    <= cfg_data[24:0];
                bzc_pkg::CFG_SEQ_DIGITS:  seq_digits_reg  <= cfg_data[23:0];
                bzc_pkg::CFG_SEQ_COUNT:   seq_count_reg   <= cfg_data[2:0];
                default:                  ; // drop writes beyond the register list
            endcase
        end
    end

    // Cell k of the square sits at bits 5k+4..5k of the joined key.
    always_comb
    begin
        cfg.encode_mode = encode_mode_reg;
        cfg.cells       = {key_high_reg, key_mid_reg, key_low_reg};
        cfg.digits      = seq_digits_reg;
        cfg.count       = seq_count_reg;
    end

    bzc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .letter_in   (letter_in),
        .message_end (message_end),
        .qstat       (qstat),
        .push        (push)
    );

    bzc_queue #(
        .RING_DEPTH (RING_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .qstat   (qstat),
        .rd      (rd),
        .rd_addr (rd_addr),
        .head    (head),
        .rd_data (rd_data)
    );

    bzc_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .rd           (rd),
        .rd_addr      (rd_addr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .group_last   (group_last),
        .message_last (message_last)
    );

    // The ring read register is the output payload; blank entries hold letter zero.
    assign letter_out = rd_data[4:0];
    assign blank_out  = rd_data[5];

endmodule

`default_nettype wire

[src/bzc_checker.sv]
// Port-level checker of the Bazeries cipher stream, bound to the top level.
`default_nettype none

module bzc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [4:0] letter_out,
    input wire logic       blank_out,
    input wire logic       group_last,
    input wire logic       message_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable({letter_out, blank_out, group_last, message_last}))
        else $error("output payload changed while stalled");

    a_msg_closes_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_last |-> group_last)
        else $error("message end without group end");

    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && blank_out |-> letter_out == 5'd0)
        else $error("blank item carries a letter");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !blank_out |-> letter_out <= 5'd25)
        else $error("output letter out of range");

endmodule

bind bazeries_cipher_stream bzc_checker u_bzc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .letter_out   (letter_out),
    .blank_out    (blank_out),
    .group_last   (group_last),
    .message_last (message_last)
);

`default_nettype wire

[verif/bzc_result_checker.sv]
// Result checker for the Bazeries cipher stream: mirrors the registers, predicts and compares.
`default_nettype none

module bzc_result_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [bzc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [4:0]                     letter_in,
    input  wire logic                           message_end,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [4:0]                     letter_out,
    input  wire logic                           blank_out,
    input  wire logic                           group_last,
    input  wire logic                           message_last,
    output int                                  fail_count,
    output int                                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_BITS = bzc_pkg::KEY_BITS;
    localparam int DATA_W   = bzc_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [4:0] letter;
        logic       blank;
        logic       group_end;
        logic       msg_end;
    } cipher_out_t;

    cipher_out_t         expected_q [$];

    logic                mode_r;
    logic [KEY_BITS-1:0] cells_r;
    logic [23:0]         digits_r;
    logic [2:0]          count_r;

    // blank flag above the letter, as the block holds a group
    logic [5:0]          held_codes [bzc_pkg::GROUP_MAX];
    int                  fill_r;
    int                  digit_idx;

    function automatic logic [4:0] cell_letter(int c);
        logic [4:0] v;
        v = cells_r[5*c +: 5];
        return (v > bzc_pkg::CELL_LETTERS) ? 5'd0 : v;
    endfunction

    function automatic logic [5:0] substituted(logic [4:0] l);
        int         pos;
        int         found;
        int         t;
        logic [4:0] v;
        if (l > bzc_pkg::LETTER_LAST)
        begin
            return {1'b1, 5'd0};
        end
        if (mode_r)
        begin
            // j shares the cell of i
            pos = (l <= bzc_pkg::LETTER_I) ? int'(l) : int'(l) - 1;
            v = cell_letter((pos % bzc_pkg::SQUARE_SIDE) * bzc_pkg::SQUARE_SIDE
                            + pos / bzc_pkg::SQUARE_SIDE);
            return (v == 5'd0) ? {1'b1, 5'd0} : {1'b0, 5'(v - 5'd1)};
        end
        // highest cell holding the letter wins
        found = -1;
        for (int c = 0; c < bzc_pkg::CELL_COUNT; c++)
        begin
            if (int'(cell_letter(c)) == int'(l) + 1)
            begin
                found = c;
            end
        end
        if (found < 0)
        begin
            return {1'b1, 5'd0};
        end
        t = (found % bzc_pkg::SQUARE_SIDE) * bzc_pkg::SQUARE_SIDE
            + found / bzc_pkg::SQUARE_SIDE;
        if (t > bzc_pkg::LETTER_I)
        begin
            t++;
        end
        return {1'b0, 5'(t)};
    endfunction

    function automatic int digits_in_use();
        int n;
        n = int'(count_r);
        if (n == 0)
        begin
            n = 1;
        end
        return (n > bzc_pkg::SEQ_DIGITS_MAX) ? bzc_pkg::SEQ_DIGITS_MAX : n;
    endfunction

    // Advance the digit position past zero digits and give the group length.
    function automatic int next_group_len();
        int n;
        int d;
        n = digits_in_use();
        if (digit_idx >= n)
        begin
            digit_idx = 0;
        end
        for (int tries = 0; tries < n; tries++)
        begin
            d = int'(digits_r[4*digit_idx +: 4]);
            if (d > bzc_pkg::DIGIT_MAX)
            begin
                d = bzc_pkg::DIGIT_MAX;
            end
            if (d != 0)
            begin
                return d;
            end
            digit_idx = (digit_idx + 1) % n;
        end
        digit_idx = 0;
        return 1;
    endfunction

    task automatic take_letter(input logic [4:0] l, input logic last);
        int          len;
        int          n;
        logic [5:0]  code;
        cipher_out_t r;
        len = next_group_len();
        if (fill_r < bzc_pkg::GROUP_MAX)
        begin
            held_codes[fill_r] = substituted(l);
        end
        fill_r++;
        if (fill_r < len && !last)
        begin
            return;
        end
        n = (fill_r > bzc_pkg::GROUP_MAX) ? bzc_pkg::GROUP_MAX : fill_r;
        for (int k = 0; k < n; k++)
        begin
            code        = held_codes[n - 1 - k];
            r.letter    = code[4:0];
            r.blank     = code[5];
            r.group_end = (k == n - 1);
            r.msg_end   = (k == n - 1) && last;
            expected_q.push_back(r);
        end
        fill_r    = 0;
        digit_idx = last ? 0 : (digit_idx + 1) % digits_in_use();
    endtask

    task automatic check_result();
        cipher_out_t seen;
        cipher_out_t want;
        seen = {letter_out, blank_out, group_last, message_last};
        if (expected_q.size() == 0)
        begin
            if (fail_count < 10)
            begin
                $display("%0t: unexpected item letter %0d blank %0b grp %0b msg %0b",
                         $time, seen.letter, seen.blank, seen.group_end, seen.msg_end);
            end
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        if (seen !== want)
        begin
            if (fail_count < 10)
            begin
                $display("%0t: exp/act letter %0d/%0d blank %0b/%0b grp %0b/%0b msg %0b/%0b",
                         $time, want.letter, seen.letter, want.blank, seen.blank,
                         want.group_end, seen.group_end, want.msg_end, seen.msg_end);
            end
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_r    = 1'b0;
            cells_r   = '0;
            digits_r  = 24'd1;
            count_r   = 3'd1;
            fill_r    = 0;
            digit_idx = 0;
            expected_q.delete();
            fail_count = 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (in_valid && !in_stall)
            begin
                take_letter(letter_in, message_end);
            end
            if (cfg_write)
            begin
                case (bzc_pkg::cfg_index_t'(cfg_index))
                    bzc_pkg::CFG_ENCODE_MODE: mode_r = cfg_data[0];
                    bzc_pkg::CFG_KEY_LOW:     cells_r[0 +: DATA_W] = cfg_data;
                    bzc_pkg::CFG_KEY_MID:     cells_r[DATA_W +: DATA_W] = cfg_data;
                    bzc_pkg::CFG_KEY_HIGH:    cells_r[KEY_BITS-1:2*DATA_W] =
                                                  cfg_data[KEY_BITS-2*DATA_W-1:0];
                    bzc_pkg::CFG_SEQ_DIGITS:  digits_r = cfg_data[23:0];
                    bzc_pkg::CFG_SEQ_COUNT:   count_r = cfg_data[2:0];
                    default: ;
                endcase
            end
            pending_results <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

[verif/tb_bazeries_cipher_stream.sv]
// Testbench top for the Bazeries cipher stream: clock, reset, register writes, letter stimulus.
`default_nettype none

module tb_bazeries_cipher_stream;
    timeunit 1ns;
    timeprecision 1ps;

    // Far beyond the slowest correct run: every group of nine, every result held
    // by a stalled receiver, plus the long hold-off.
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DATA_W      = bzc_pkg::CFG_DATA_W;
    localparam int KEY_BITS    = bzc_pkg::KEY_BITS;
    localparam int CELLS       = bzc_pkg::CELL_COUNT;

    typedef enum int {
        KEY_EMPTY,
        KEY_SATURATED,
        KEY_PERMUTED,
        KEY_NOISY
    } key_style_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [2:0]            cfg_index   = '0;
    logic [DATA_W-1:0]     cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [4:0]            letter_in   = '0;
    logic                  message_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [4:0]            letter_out;
    logic                  blank_out;
    logic                  group_last;
    logic                  message_last;

    int                    fail_count;
    int                    pending_results;

    // Square contents as written next, one five-bit cell each.
    logic [4:0]            square [CELLS];

    // calm: no random idling on either side. hold_requests: bump to start a hold-off.
    bit                    calm          = 1'b0;
    int                    hold_requests = 0;
    int                    holds_taken   = 0;
    int                    hold_left     = 0;
    int                    cycle_count   = 0;

    bazeries_cipher_stream dut (.*);

    bzc_result_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch when asked,
    // so the ring and the group queue fill and the input side stalls.
    always @(posedge clk)
    begin
        if (hold_requests != holds_taken)
        begin
            holds_taken <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    task automatic put_reg(input bzc_pkg::cfg_index_t idx, input logic [DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write every register back to back, the square from the current cell array.
    task automatic write_settings(input bit mode, input logic [23:0] digits,
                                  input logic [2:0] count);
        logic [KEY_BITS-1:0] packed_cells;
        for (int c = 0; c < CELLS; c++)
        begin
            packed_cells[5*c +: 5] = square[c];
        end
        put_reg(bzc_pkg::CFG_ENCODE_MODE, DATA_W'(mode));
        put_reg(bzc_pkg::CFG_KEY_LOW, packed_cells[0 +: DATA_W]);
        put_reg(bzc_pkg::CFG_KEY_MID, packed_cells[DATA_W +: DATA_W]);
        put_reg(bzc_pkg::CFG_KEY_HIGH, DATA_W'(packed_cells[KEY_BITS-1:2*DATA_W]));
        put_reg(bzc_pkg::CFG_SEQ_DIGITS, DATA_W'(digits));
        put_reg(bzc_pkg::CFG_SEQ_COUNT, DATA_W'(count));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic fill_square(input key_style_t style);
        logic [4:0] order [26];
        logic [4:0] swap;
        int         pick;
        for (int k = 0; k < 26; k++)
        begin
            order[k] = 5'(k + 1);
        end
        // shuffle the alphabet; the letter left in the last slot is missing from the key
        for (int k = 25; k > 0; k--)
        begin
            pick        = $urandom_range(k);
            swap        = order[k];
            order[k]    = order[pick];
            order[pick] = swap;
        end
        for (int c = 0; c < CELLS; c++)
        begin
            case (style)
                KEY_EMPTY:     square[c] = 5'd0;
                KEY_SATURATED: square[c] = 5'd31;
                KEY_PERMUTED:  square[c] = order[c];
                default:       square[c] = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                                    : 5'($urandom_range(1, 26));
            endcase
        end
    endtask

    // Offer one item and hold it until the block takes it. Valid stays high
    // across back-to-back items; idle cycles drop it.
    task automatic send_letter(input logic [4:0] letter, input bit last);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        letter_in   <= letter;
        message_end <= last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Mostly letters, some out of range; messages end at random.
    task automatic random_phase(input int items, input bit close_message);
        logic [4:0] l;
        bit         last;
        for (int k = 0; k < items; k++)
        begin
            l    = ($urandom_range(9) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(25));
            last = (k == items - 1) ? close_message : ($urandom_range(9) == 0);
            send_letter(l, last);
        end
        drain();
    endtask

    initial
    begin
        key_style_t style;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: decode with an empty square, so every item is blank,
        // in groups of one.
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b1);
        drain();

        // Encode through a full square. Digits 3, 0, 2: skip the zero digit.
        // i and j land on the same cell; 26 is out of range. The message end
        // cuts the third group short.
        fill_square(KEY_PERMUTED);
        write_settings(1'b1, 24'h000203, 3'd3);
        send_letter(5'd8, 1'b0);
        send_letter(5'd9, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd26, 1'b0);
        send_letter(5'd4, 1'b1);
        drain();

        // Decode with f placed twice: the higher cell must win. All digits zero
        // gives groups of one.
        fill_square(KEY_NOISY);
        square[3]  = 5'd6;
        square[21] = 5'd6;
        write_settings(1'b0, 24'h000000, 3'd6);
        send_letter(5'd5, 1'b0);
        send_letter(5'd8, 1'b0);
        send_letter(5'd30, 1'b0);
        send_letter(5'd17, 1'b1);
        drain();

        // Cells above z read as empty; digits above nine clamp to nine and a
        // count of seven clamps to six: one full group of nine.
        fill_square(KEY_SATURATED);
        write_settings(1'b1, 24'hFFFFFF, 3'd7);
        for (int k = 0; k < 9; k++)
        begin
            send_letter(5'(k * 3), k == 8);
        end
        drain();

        // Change the digits in the middle of a group: groups 1, 1, 9 leave the
        // position at digit 2 with four letters held. The new count of two puts
        // the position past the end, and the new length of three is already
        // below the fill.
        fill_square(KEY_PERMUTED);
        write_settings(1'b1, 24'h000911, 3'd3);
        for (int k = 0; k < 6; k++)
        begin
            send_letter(5'($urandom_range(25)), 1'b0);
        end
        drain();
        write_settings(1'b1, 24'h000003, 3'd2);
        send_letter(5'($urandom_range(25)), 1'b0);
        send_letter(5'($urandom_range(25)), 1'b1);
        drain();

        // Random settings and letters. The first phase stops mid-group so the
        // next register write lands on a partly filled group; the second runs
        // longer with no idling at all.
        for (int p = 0; p < 3; p++)
        begin
            style = ($urandom_range(9) < 6) ? KEY_PERMUTED : key_style_t'($urandom_range(3));
            fill_square(style);
            write_settings($urandom_range(1), 24'($urandom()), 3'($urandom_range(7)));
            calm = (p == 1);
            random_phase((p == 1) ? 32 : 12, p != 0);
        end
        calm = 1'b0;

        // Back-pressure: short groups while the receiver holds off, so the
        // block fills up and stalls the input.
        fill_square(KEY_PERMUTED);
        write_settings(1'b1, 24'h000002, 3'd1);
        calm = 1'b1;
        hold_requests++;
        random_phase(28, 1'b1);
        calm = 1'b0;

        if (fail_count == 0 && pending_results == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/bzc_pkg.sv
src/bzc_front.sv
src/bzc_queue.sv
src/bzc_back.sv
src/bazeries_cipher_stream.sv
src/bzc_checker.sv
verif/bzc_result_checker.sv
verif/tb_bazeries_cipher_stream.sv
